[rtl/core/hfc_pkg.sv]
`timescale 1ns / 1ps

package hfc_pkg;

  typedef enum logic [1:0] {
    FMT_HALF  = 2'd0,
    FMT_FLOAT = 2'd1,
    FMT_UINT  = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    REG_SRC  = 2'd0,
    REG_DST  = 2'd1,
    REG_NORM = 2'd2
  } reg_e;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] SRC_RESET  = 2'd1;
  localparam logic [1:0] DST_RESET  = 2'd1;
  localparam logic       NORM_RESET = 1'b0;

  typedef struct packed {
    logic [31:0] sample_in;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    fmt_e src;
    fmt_e dst;
    logic norm;
    logic last;
  } ctl_t;

  // code three reads as float
  function automatic fmt_e fmt_decode(logic [1:0] c);
    fmt_e f;
    case (c)
      2'd0:    f = FMT_HALF;
      2'd2:    f = FMT_UINT;
      default: f = FMT_FLOAT;
    endcase
    return f;
  endfunction

  function automatic logic [5:0] lzc32(logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && x[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [31:0] r;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [10:0] mm;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    mm = 11'd0;
    if (e == 5'h1F) begin
      r = {h[15], 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {h[15], 31'd0};
      end else begin
        for (int i = 0; i < 10; i++) begin
          if (m[i]) p = 4'(i);
        end
        mm = {1'b0, m} << (4'd10 - p);
        r = {h[15], 8'(p) + 8'd103, mm[9:0], 13'd0};
      end
    end else begin
      r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [15:0] f32_to_half(logic [31:0] x);
    logic [15:0] r;
    logic [7:0]  e;
    logic [22:0] m;
    logic [14:0] h;
    logic [12:0] rem13;
    logic [23:0] full, hs, msk, rem, hp;
    logic [4:0]  sh;
    e = x[30:23];
    m = x[22:0];
    h = 15'd0;
    rem13 = 13'd0;
    full = {1'b1, m};
    hs = 24'd0;
    msk = 24'd0;
    rem = 24'd0;
    hp = 24'd0;
    sh = 5'd0;
    if (e == 8'hFF) begin
      // nan sets the quiet bit and keeps the top payload bits
      r = (m != 23'd0) ? {x[31], 5'h1F, 1'b1, m[21:13]} : {x[31], 15'h7C00};
    end else if (e < 8'd102) begin
      r = {x[31], 15'd0};
    end else if (e > 8'd142) begin
      r = {x[31], 15'h7C00};
    end else if (e >= 8'd113) begin
      h = {5'(e - 8'd112), m[22:13]};
      rem13 = m[12:0];
      if (rem13 > 13'h1000 || (rem13 == 13'h1000 && h[0])) h = h + 15'd1;
      r = {x[31], h};
    end else begin
      sh = 5'(8'd126 - e);
      hs = full >> sh;
      msk = (24'd1 << sh) - 24'd1;
      rem = full & msk;
      hp = 24'd1 << (sh - 5'd1);
      h = hs[14:0];
      if (rem > hp || (rem == hp && h[0])) h = h + 15'd1;
      r = {x[31], h};
    end
    return r;
  endfunction

endpackage

[rtl/core/hfc_widen.sv]
`timescale 1ns / 1ps

module hfc_widen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [31:0]   sample_i,
  input  hfc_pkg::ctl_t ctl_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [31:0]   data_o,
  output hfc_pkg::ctl_t ctl_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  hfc_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [31:0] d1_q, d1_d, d2_q, d3_q, d4_q, d4_d;
  logic [5:0]  lz1_q;
  logic [63:0] nn2_q, nn2_d, n2;
  logic [7:0]  ex2_q, ex2_d, ex3_q;
  logic        zr2_q, zr3_q;
  logic [53:0] r3_q, r3_d;
  logic        inc3, inc4;
  logic [24:0] t4;
  logic [7:0]  ex4;
  logic [22:0] mt4;
  logic [31:0] fu4;

  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v4_q;
  assign data_o  = d4_q;
  assign ctl_o   = ctl4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: pass-through, half widening, leading zeros of uint
  always_comb begin
    if (ctl_i.src == ctl_i.dst) begin
      d1_d = (ctl_i.src == hfc_pkg::FMT_HALF) ? {16'd0, sample_i[15:0]} : sample_i;
    end else if (ctl_i.src == hfc_pkg::FMT_HALF) begin
      d1_d = hfc_pkg::half_to_f32(sample_i[15:0]);
    end else begin
      d1_d = sample_i;
    end
  end

  // stage 2: uint normalize; normalized mode is {u,u} scaled by 2^-64
  always_comb begin
    n2 = ctl1_q.norm ? {d1_q, d1_q} : {d1_q, 32'd0};
    nn2_d = n2 << lz1_q[4:0];
    ex2_d = (ctl1_q.norm ? 8'd126 : 8'd158) - {2'b00, lz1_q};
  end

  // stage 3: round to binary64 precision
  always_comb begin
    inc3 = nn2_q[10] && ((|nn2_q[9:0]) || nn2_q[11]);
    r3_d = {1'b0, nn2_q[63:11]} + {53'd0, inc3};
  end

  // stage 4: round to binary32 and pack
  always_comb begin
    inc4 = r3_q[28] && ((|r3_q[27:0]) || r3_q[29]);
    t4 = {1'b0, r3_q[52:29]} + {24'd0, inc4};
    if (r3_q[53] || t4[24]) begin
      ex4 = ex3_q + 8'd1;
      mt4 = 23'd0;
    end else begin
      ex4 = ex3_q;
      mt4 = t4[22:0];
    end
    fu4 = zr3_q ? 32'd0 : {1'b0, ex4, mt4};
    if (ctl3_q.src == hfc_pkg::FMT_UINT && ctl3_q.dst != hfc_pkg::FMT_UINT) d4_d = fu4;
    else d4_d = d3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      ctl1_q <= ctl_i;
      d1_q   <= d1_d;
      lz1_q  <= hfc_pkg::lzc32(sample_i);
    end
    if (en2 && v1_q) begin
      ctl2_q <= ctl1_q;
      d2_q   <= d1_q;
      nn2_q  <= nn2_d;
      ex2_q  <= ex2_d;
      zr2_q  <= lz1_q[5];
    end
    if (en3 && v2_q) begin
      ctl3_q <= ctl2_q;
      d3_q   <= d2_q;
      r3_q   <= r3_d;
      ex3_q  <= ex2_q;
      zr3_q  <= zr2_q;
    end
    if (en4 && v3_q) begin
      ctl4_q <= ctl3_q;
      d4_q   <= d4_d;
    end
  end

endmodule

[rtl/core/hfc_narrow.sv]
`timescale 1ns / 1ps

module hfc_narrow (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [31:0]        data_i,
  input  hfc_pkg::ctl_t      ctl_i,
  output logic               valid_o,
  input  logic               stall_i,
  output hfc_pkg::out_item_t data_o
);

  function automatic logic [5:0] top_pos56(logic [55:0] p);
    logic [5:0] l;
    l = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (p[i]) l = 6'(i);
    end
    return l;
  endfunction

  logic v5_q, v6_q, v7_q, v8_q, v9_q;
  logic en5, en6, en7, en8, en9;

  hfc_pkg::ctl_t ctl5_q, ctl6_q, ctl7_q, ctl8_q;
  hfc_pkg::out_item_t out9_q, out9_d;

  logic [31:0] dat5_q, dat6_q, dat7_q, dat8_q, dat5_d;
  logic [9:0]  e5_q, e6_q, e7_q, e5_d;
  logic        zf5_q, zf6_q, zf7_q, zf8_q, zf5_d;
  logic        sf5_q, sf6_q, sf7_q, sf8_q, sf5_d;
  logic [55:0] p5_q, p6_q, p5_d;
  logic [23:0] m5;
  logic [5:0]  l6_q, l7_q;
  logic [56:0] p7_q, p7_d;
  logic [1:0]  k7;
  logic [55:0] ulp7, lowm7, halfv7, rem7;
  logic        up7;
  logic [5:0]  lp8, lq8;
  logic [10:0] le8;
  logic [63:0] pe8;
  logic [9:0]  s8;
  logic [5:0]  sh8;
  logic [31:0] int8_q, int8_d;
  logic        g8_q, g8_d, st8_q, st8_d, ovf8_q, ovf8_d;
  logic [31:0] sum9, uv9;
  logic        clamp9;

  assign en9 = !v9_q || !stall_i;
  assign en8 = !v8_q || en9;
  assign en7 = !v7_q || en8;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign stall_o = !en5;
  assign valid_o = v9_q;
  assign data_o  = out9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
      if (en9) v9_q <= v8_q;
    end
  end

  // stage 5: half narrowing; uint path forms the binary64 product
  always_comb begin
    if (ctl_i.src != ctl_i.dst && ctl_i.dst == hfc_pkg::FMT_HALF) begin
      dat5_d = {16'd0, hfc_pkg::f32_to_half(data_i)};
    end else begin
      dat5_d = data_i;
    end
    m5 = (data_i[30:23] == 8'd0) ? {1'b0, data_i[22:0]} : {1'b1, data_i[22:0]};
    e5_d = (data_i[30:23] == 8'd0) ? 10'(-149) : {2'b00, data_i[30:23]} - 10'd150;
    // scale by 2^32-1 as a shift and subtract
    p5_d = ctl_i.norm ? ({m5, 32'd0} - {32'd0, m5}) : {32'd0, m5};
    // negatives and nan go to zero
    zf5_d = data_i[31] || (data_i[30:23] == 8'hFF && data_i[22:0] != 23'd0) ||
            (m5 == 24'd0);
    sf5_d = (data_i[30:23] == 8'hFF);
  end

  // stage 7: round the product to 53 significant bits
  always_comb begin
    k7 = (l6_q > 6'd52) ? 2'(l6_q - 6'd52) : 2'd0;
    ulp7 = 56'd1 << k7;
    lowm7 = ulp7 - 56'd1;
    halfv7 = ulp7 >> 1;
    rem7 = p6_q & lowm7;
    up7 = (k7 != 2'd0) &&
          ((rem7 > halfv7) || (rem7 == halfv7 && (p6_q & ulp7) != 56'd0));
    p7_d = {1'b0, p6_q & ~lowm7} + (up7 ? {1'b0, ulp7} : 57'd0);
  end

  // stage 8: align to integer, keep guard and sticky
  always_comb begin
    lq8 = l7_q + 6'd1;
    lp8 = p7_q[lq8] ? lq8 : l7_q;
    le8 = {5'd0, lp8} + {e7_q[9], e7_q};
    ovf8_d = !le8[10] && (le8[9:0] >= 10'd32);
    pe8 = {7'd0, p7_q};
    s8 = 10'd0;
    sh8 = 6'd0;
    if (!e7_q[9]) begin
      int8_d = 32'(pe8 << e7_q[4:0]);
      g8_d = 1'b0;
      st8_d = 1'b0;
    end else begin
      s8 = ~e7_q + 10'd1;
      if (s8 > 10'd63) begin
        int8_d = 32'd0;
        g8_d = 1'b0;
        st8_d = |pe8;
      end else begin
        sh8 = s8[5:0];
        int8_d = 32'(pe8 >> sh8);
        g8_d = pe8[sh8 - 6'd1];
        st8_d = |(pe8 & ((64'd1 << (sh8 - 6'd1)) - 64'd1));
      end
    end
  end

  // stage 9: round half to even, clamp, pick the result
  always_comb begin
    sum9 = int8_q + {31'd0, g8_q && (st8_q || int8_q[0])};
    clamp9 = ovf8_q || sf8_q || (int8_q == 32'hFFFF_FFFF && (g8_q || st8_q));
    uv9 = zf8_q ? 32'd0 : (clamp9 ? 32'hFFFF_FFFF : sum9);
    if (ctl8_q.src != ctl8_q.dst && ctl8_q.dst == hfc_pkg::FMT_UINT) begin
      out9_d.sample_out = uv9;
    end else begin
      out9_d.sample_out = dat8_q;
    end
    out9_d.last_out = ctl8_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en5 && valid_i) begin
      ctl5_q <= ctl_i;
      dat5_q <= dat5_d;
      p5_q   <= p5_d;
      e5_q   <= e5_d;
      zf5_q  <= zf5_d;
      sf5_q  <= sf5_d;
    end
    if (en6 && v5_q) begin
      ctl6_q <= ctl5_q;
      dat6_q <= dat5_q;
      p6_q   <= p5_q;
      l6_q   <= top_pos56(p5_q);
      e6_q   <= e5_q;
      zf6_q  <= zf5_q;
      sf6_q  <= sf5_q;
    end
    if (en7 && v6_q) begin
      ctl7_q <= ctl6_q;
      dat7_q <= dat6_q;
      p7_q   <= p7_d;
      l7_q   <= l6_q;
      e7_q   <= e6_q;
      zf7_q  <= zf6_q;
      sf7_q  <= sf6_q;
    end
    if (en8 && v7_q) begin
      ctl8_q <= ctl7_q;
      dat8_q <= dat7_q;
      int8_q <= int8_d;
      g8_q   <= g8_d;
      st8_q  <= st8_d;
      ovf8_q <= ovf8_d;
      zf8_q  <= zf7_q;
      sf8_q  <= sf7_q;
    end
    if (en9 && v8_q) begin
      out9_q <= out9_d;
    end
  end

endmodule

[rtl/core/half_float_uint32_sample_convert.sv]
`timescale 1ns / 1ps
// Sample format converter: half, float32 and uint32, one 32-bit sample per transaction.
// Input channel in_valid_i/in_stall_o carries sample_in (a half sits in the low
// 16 bits) and last_sample; the output channel out_valid_o/out_stall_i returns
// sample_out and last_out, one result per input, in order.
// Formats and the normalized flag are set over the APB port: source_format at
// 0x0, dest_format at 0x4, normalized at 0x8; change them only while idle.
// Four stages widen to float32 (leading-zero count, shift, two rounding steps)
// and five narrow (half pack or product, leading-one search, binary64
// rounding, alignment, integer rounding and clamp). One transaction per cycle
// is sustained while out_stall_i is low.
// Each stage holds a valid bit; when out_stall_i is high the results and the
// stages behind them hold, and empty stages still fill, so in_stall_o rises
// only once every stage holds an item.
// Reset clears all valid bits and sets the formats to float32, normalized off.
module half_float_uint32_sample_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hfc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hfc_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hfc_pkg::APB_AW-1:0]    paddr,
  input  logic [hfc_pkg::APB_DW-1:0]    pwdata,
  output logic [hfc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [1:0] src_q, dst_q;
  logic       norm_q;
  logic       wr_en;
  hfc_pkg::reg_e reg_idx;

  hfc_pkg::ctl_t in_ctl, mid_ctl;
  logic          mid_valid, mid_stall;
  logic [31:0]   mid_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = hfc_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= hfc_pkg::SRC_RESET;
      dst_q  <= hfc_pkg::DST_RESET;
      norm_q <= hfc_pkg::NORM_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        hfc_pkg::REG_SRC:  src_q  <= pwdata[1:0];
        hfc_pkg::REG_DST:  dst_q  <= pwdata[1:0];
        hfc_pkg::REG_NORM: norm_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hfc_pkg::REG_SRC:  prdata = {30'd0, src_q};
      hfc_pkg::REG_DST:  prdata = {30'd0, dst_q};
      hfc_pkg::REG_NORM: prdata = {31'd0, norm_q};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    in_ctl.src  = hfc_pkg::fmt_decode(src_q);
    in_ctl.dst  = hfc_pkg::fmt_decode(dst_q);
    in_ctl.norm = norm_q;
    in_ctl.last = in_data_i.last_sample;
  end

  hfc_widen u_widen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .sample_i (in_data_i.sample_in),
    .ctl_i    (in_ctl),
    .valid_o  (mid_valid),
    .stall_i  (mid_stall),
    .data_o   (mid_data),
    .ctl_o    (mid_ctl)
  );

  hfc_narrow u_narrow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .stall_o (mid_stall),
    .data_i  (mid_data),
    .ctl_i   (mid_ctl),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

[rtl/core/hfc_checker.sv]
`timescale 1ns / 1ps

module hfc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input hfc_pkg::out_item_t         out_data_o,
  input logic                       psel,
  input logic                       pwrite,
  input logic [hfc_pkg::APB_DW-1:0] prdata
);

  // a held result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // input backpressure only comes from a full pipe behind a stalled output
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  a_reg_read_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> prdata[31:2] == 30'd0)
    else $error("register read has stray upper bits");

endmodule

bind half_float_uint32_sample_convert hfc_checker u_hfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .pwrite      (pwrite),
  .prdata      (prdata)
);
